/* sv/ple_pkg.sv */
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

	localparam int CMD_BITS = 3;
	localparam int POS_BITS = 6;
	localparam int LEN_BITS = 6;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_GET     = 3'd3,
		CMD_REPLACE = 3'd4
	} ple_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INS  = 5'b00010,
		ST_FILL = 5'b00100,
		ST_REM  = 5'b01000,
		ST_GET  = 5'b10000
	} ple_state_t;

endpackage

`default_nettype wire

/* sv/positional_list_engine_top.sv */
// Top level of the positional list engine: command sequencer around the entry store.
`default_nettype none

// Ordered list of up to CAPACITY entries, addressed by one-based position.
// A command beat is taken when start is high and busy is low; its result
// comes back as a one-cycle done strobe that cannot be held off, so the
// receiver must capture ok, entry_out, length and empty_res on that cycle.
// All entries live in one single-port-write memory with a registered read,
// and every shift moves one entry per cycle through that write port.
// Append, replace, any rejected command and removal of the last entry
// answer from the accept itself; get first reads the entry; insert at p
// moves entries p..count down one, last first, then writes the new one
// (p = count + 1 is an append); remove at p moves the entries after p up
// one. Busy stays high until the cycle the result is registered, so a new
// command may follow in the very cycle its predecessor's done strobe is
// shown. Entries need no clearing after reset: only positions 1..length are ever read.
module positional_list_engine_top
	import ple_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int ENTRY_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [CMD_BITS-1:0]   cmd,
	input  wire logic [POS_BITS-1:0]   position,
	input  wire logic [ENTRY_BITS-1:0] entry_in,
	output logic                       done,
	output logic                       ok,
	output logic [ENTRY_BITS-1:0]      entry_out,
	output logic [LEN_BITS-1:0]        length,
	output logic                       empty_res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [POS_BITS:0] CAP_W = (POS_BITS + 1)'(CAPACITY);

	ple_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] tgt_q;
	logic [ENTRY_BITS-1:0] item_q;

	logic accept;
	logic [POS_BITS:0] pos_w, cnt_w;
	logic ins_ok, pos_ok;
	logic [AW-1:0] tgt;

	logic res_fire, res_ok;
	logic [ENTRY_BITS-1:0] res_entry;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

	logic done_q, ok_q, empty_q;
	logic [ENTRY_BITS-1:0] entry_out_q;
	logic [LEN_BITS-1:0] length_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Bounds checks in one extra bit so count + 1 never wraps.
	assign pos_w  = {1'b0, position};
	assign cnt_w  = (POS_BITS + 1)'(cnt_q);
	assign ins_ok = (cnt_w < CAP_W) && (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
	assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
	assign tgt    = AW'(pos_w - 1'b1);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		res_fire  = 1'b0;
		res_ok    = 1'b0;
		res_entry = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = entry_in;
		ram_re    = 1'b0;
		ram_raddr = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_fire = 1'b1;
					case (ple_cmd_t'(cmd))
						CMD_APPEND: begin
							if (cnt_w < CAP_W) begin
								ram_we    = 1'b1;
								ram_waddr = AW'(cnt_q);
								cnt_d     = cnt_q + 1'b1;
								res_ok    = 1'b1;
							end
						end
						CMD_INSERT: begin
							if (ins_ok) begin
								if (pos_w == cnt_w + 1'b1) begin
									ram_we    = 1'b1;
									ram_waddr = tgt;
									cnt_d     = cnt_q + 1'b1;
									res_ok    = 1'b1;
								end else begin
									// Walk down from the last entry, one move a cycle.
									res_fire  = 1'b0;
									ram_re    = 1'b1;
									ram_raddr = AW'(cnt_q - 1'b1);
									idx_d     = AW'(cnt_q - 1'b1);
									state_d   = ST_INS;
								end
							end
						end
						CMD_REMOVE: begin
							if (pos_ok) begin
								if (pos_w == cnt_w) begin
									cnt_d  = cnt_q - 1'b1;
									res_ok = 1'b1;
								end else begin
									res_fire  = 1'b0;
									ram_re    = 1'b1;
									ram_raddr = AW'(tgt + 1'b1);
									idx_d     = AW'(tgt + 1'b1);
									state_d   = ST_REM;
								end
							end
						end
						CMD_GET: begin
							if (pos_ok) begin
								res_fire  = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = tgt;
								state_d   = ST_GET;
							end
						end
						CMD_REPLACE: begin
							if (pos_ok) begin
								ram_we    = 1'b1;
								ram_waddr = tgt;
								res_ok    = 1'b1;
							end
						end
						default: begin
							res_ok = 1'b0;
						end
					endcase
				end
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q + 1'b1);
				ram_wdata = ram_rdata;
				if (idx_q == tgt_q) begin
					state_d = ST_FILL;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q - 1'b1);
					idx_d     = AW'(idx_q - 1'b1);
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = item_q;
				cnt_d     = cnt_q + 1'b1;
				res_fire  = 1'b1;
				res_ok    = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_REM: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_q - 1'b1);
				ram_wdata = ram_rdata;
				if (idx_q == AW'(cnt_q - 1'b1)) begin
					cnt_d    = cnt_q - 1'b1;
					res_fire = 1'b1;
					res_ok   = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q + 1'b1);
					idx_d     = AW'(idx_q + 1'b1);
				end
			end
			ST_GET: begin
				res_fire  = 1'b1;
				res_ok    = 1'b1;
				res_entry = ram_rdata;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ple_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ENTRY_BITS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= res_fire;
		end
	end

	// Hold the command operands, the walk pointer and the result; no reset needed.
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			tgt_q  <= tgt;
			item_q <= entry_in;
		end
		if (res_fire) begin
			ok_q        <= res_ok;
			entry_out_q <= res_entry;
			length_q    <= LEN_BITS'(cnt_d);
			empty_q     <= (cnt_d == '0);
		end
	end

	assign done      = done_q;
	assign ok        = ok_q;
	assign entry_out = entry_out_q;
	assign length    = length_q;
	assign empty_res = empty_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_idle_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && !start |=> $stable(cnt_q))
		else $error("length moved without a command");

	a_get_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GET) |=> done && ok)
		else $error("get read did not produce a result");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) || (state_q == ST_FILL) |-> ((CW + 1)'(cnt_q) < (CW + 1)'(CAPACITY)))
		else $error("insert shift running on a full list");

	a_empty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (empty_res == (length == '0)))
		else $error("empty flag disagrees with length");

endmodule

`default_nettype wire

/* sv/ple_ram.sv */
// Entry store: one write port, one read port, registered read data.
`default_nettype none

module ple_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
